>>> rtl/tbs_pkg.sv
// tbs_pkg: command, register and pixel mode codes for the tile bilinear sampler.
// No dependencies; used by the sampler top level and its port checker.
package tbs_pkg;

	typedef logic [31:0] word_t;
	typedef logic [1:0]  code_t;

	localparam code_t CMD_WRITE_PIXEL   = 2'd0;
	localparam code_t CMD_WRITE_PALETTE = 2'd1;
	localparam code_t CMD_SAMPLE        = 2'd2;

	localparam code_t REG_TILE_WIDTH  = 2'd0;
	localparam code_t REG_TILE_HEIGHT = 2'd1;
	localparam code_t REG_PIXEL_MODE  = 2'd2;

	localparam code_t MODE_DIRECT = 2'd0;
	localparam code_t MODE_GREY   = 2'd1;
	localparam code_t MODE_PAL8   = 2'd2;
	localparam code_t MODE_PAL1   = 2'd3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam int         SIDE_W       = 11;
	localparam int         CFG_W        = 9;

endpackage

>>> rtl/tbs_ram.sv
// tbs_ram: generic single write port, single read port RAM with registered read.
// No dependencies; instanced for the pixel banks and the palette copies.
module tbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tile_bilinear_sampler_unit.sv
// tile_bilinear_sampler_unit: tile store, palette and five stage bilinear sample pipeline.
// Depends on tbs_pkg (codes, word type) and tbs_ram (pixel banks, palette copies).
//
//  channel   | handshake               | word
//  ----------+-------------------------+-------------------------------------------------
//  command   | start, busy (always 0)  | command, write_col/row, palette_slot,
//            |                         | write_word, sample_x, sample_y
//  result    | color_valid strobe      | color_out
//  config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// One command per cycle. A sample is registered through these steps before color_valid:
// address, pixel bank read, palette read, y blend, x blend.
// The tile sits in four banks split by column and row parity, so the four neighbors
// come out of one read port each; the palette is held four times for the same reason.
// Reset clears control state only; both stores hold garbage until written.
// Nothing stalls: busy is tied low and results cannot be held off.
module tile_bilinear_sampler_unit
	import tbs_pkg::*;
#(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       command,
	input  logic [7:0]       write_col,
	input  logic [7:0]       write_row,
	input  logic [7:0]       palette_slot,
	input  logic [31:0]      write_word,
	input  logic [15:0]      sample_x,
	input  logic [15:0]      sample_y,
	output logic [31:0]      color_out,
	output logic             color_valid,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW    = $clog2(MAX_SIDE);
	localparam int HB    = (CW > 1) ? CW - 1 : 1;
	localparam int BAW   = 2 * HB;
	localparam int BDEP  = 1 << BAW;
	localparam int F     = FRAC_BITS;
	localparam int LW    = F + 8;
	localparam int MW    = 2 * F + 9;
	localparam logic [F:0] ONE = (F + 1)'(1) << F;

	// config
	logic [CFG_W-1:0] tile_width_q, tile_height_q;
	code_t            pixel_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= CFG_W'(256);
			tile_height_q <= CFG_W'(256);
			pixel_mode_q  <= MODE_DIRECT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
				REG_TILE_HEIGHT: tile_height_q <= cfg_data;
				REG_PIXEL_MODE:  pixel_mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// stage 0: clamp coordinates
	logic [SIDE_W-1:0] w_side, h_side, w_last, h_last;
	logic [16:0]       sx_int, sy_int;
	logic              take, last_col, last_row, wr_in_range;

	always_comb begin
		if (tile_width_q == '0)
			w_side = SIDE_W'(1);
		else if (SIDE_W'(tile_width_q) > SIDE_W'(MAX_SIDE))
			w_side = SIDE_W'(MAX_SIDE);
		else
			w_side = SIDE_W'(tile_width_q);
		if (tile_height_q == '0)
			h_side = SIDE_W'(1);
		else if (SIDE_W'(tile_height_q) > SIDE_W'(MAX_SIDE))
			h_side = SIDE_W'(MAX_SIDE);
		else
			h_side = SIDE_W'(tile_height_q);
		w_last = w_side - SIDE_W'(1);
		h_last = h_side - SIDE_W'(1);
	end

	assign take        = start && !busy;
	assign sx_int      = {1'b0, sample_x} >> F;
	assign sy_int      = {1'b0, sample_y} >> F;
	assign last_col    = sx_int >= 17'(w_last);
	assign last_row    = sy_int >= 17'(h_last);
	assign wr_in_range = ({8'd0, write_col} < 16'(MAX_SIDE)) &&
		({8'd0, write_row} < 16'(MAX_SIDE));

	// stage 1
	logic          vld_s1, lcol_s1, lrow_s1, wok_s1;
	code_t         cmd_s1;
	logic [CW-1:0] ix_s1, iy_s1;
	logic [F-1:0]  fx_s1, fy_s1;
	logic [7:0]    wcol_s1, wrow_s1, slot_s1;
	word_t         word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= command;
		lcol_s1 <= last_col;
		lrow_s1 <= last_row;
		ix_s1   <= last_col ? w_last[CW-1:0] : sx_int[CW-1:0];
		iy_s1   <= last_row ? h_last[CW-1:0] : sy_int[CW-1:0];
		fx_s1   <= sample_x[F-1:0];
		fy_s1   <= sample_y[F-1:0];
		wok_s1  <= wr_in_range;
		wcol_s1 <= write_col;
		wrow_s1 <= write_row;
		slot_s1 <= palette_slot;
		word_s1 <= write_word;
	end

	// pixel banks, bank index {row parity, col parity}
	logic           pix_we;
	logic [BAW-1:0] pix_waddr;
	logic [CW-1:0]  ix_nx, iy_nx;
	word_t          bank_rd [4];

	assign pix_we    = vld_s1 && (cmd_s1 == CMD_WRITE_PIXEL) && wok_s1;
	assign pix_waddr = {HB'({8'd0, wrow_s1} >> 1), HB'({8'd0, wcol_s1} >> 1)};
	assign ix_nx     = ix_s1 + CW'(1);
	assign iy_nx     = iy_s1 + CW'(1);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [CW-1:0]  rcol, rrow;
		logic [BAW-1:0] raddr;
		logic           we;

		assign rcol  = (ix_s1[0] == b[0]) ? ix_s1 : ix_nx;
		assign rrow  = (iy_s1[0] == b[1]) ? iy_s1 : iy_nx;
		assign raddr = {HB'(16'(rrow) >> 1), HB'(16'(rcol) >> 1)};
		assign we    = pix_we && (wcol_s1[0] == b[0]) && (wrow_s1[0] == b[1]);

		tbs_ram #(.WIDTH(32), .DEPTH(BDEP)) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (pix_waddr),
			.wdata (word_s1),
			.raddr (raddr),
			.rdata (bank_rd[b])
		);
	end

	// stage 2: neighbors tl, tr, bl, br; palette lookup
	logic         vld_s2, lcol_s2, lrow_s2, px0_s2, py0_s2;
	code_t        cmd_s2;
	logic [F-1:0] fx_s2, fy_s2;
	logic [7:0]   slot_s2;
	word_t        word_s2;
	word_t        nb [4];
	word_t        pal_rd [4];
	logic         pal_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2  <= cmd_s1;
		lcol_s2 <= lcol_s1;
		lrow_s2 <= lrow_s1;
		px0_s2  <= ix_s1[0];
		py0_s2  <= iy_s1[0];
		fx_s2   <= fx_s1;
		fy_s2   <= fy_s1;
		slot_s2 <= slot_s1;
		word_s2 <= word_s1;
	end

	assign nb[0]  = bank_rd[{py0_s2, px0_s2}];
	assign nb[1]  = bank_rd[{py0_s2, ~px0_s2}];
	assign nb[2]  = bank_rd[{~py0_s2, px0_s2}];
	assign nb[3]  = bank_rd[{~py0_s2, ~px0_s2}];
	assign pal_we = vld_s2 && (cmd_s2 == CMD_WRITE_PALETTE);

	for (genvar n = 0; n < 4; n++) begin : g_pal
		logic [7:0] idx;

		assign idx = (pixel_mode_q == MODE_PAL1) ? {7'd0, nb[n][0]} : nb[n][7:0];

		tbs_ram #(.WIDTH(32), .DEPTH(256)) u_pal (
			.clk   (clk),
			.we    (pal_we),
			.waddr (slot_s2),
			.wdata (word_s2),
			.raddr (idx),
			.rdata (pal_rd[n])
		);
	end

	// stage 3: decode pixel words, y blend (x blend on the last row)
	logic         smp_s3, lcol_s3, lrow_s3;
	logic [F-1:0] fx_s3, fy_s3;
	word_t        nb_s3 [4];
	word_t        px [4];
	word_t        pa_l, pb_l, pa_r, pb_r;
	logic [F-1:0] fb;
	logic [F:0]   fa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s3 <= 1'b0;
		end else begin
			smp_s3 <= vld_s2 && (cmd_s2 == CMD_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		lcol_s3 <= lcol_s2;
		lrow_s3 <= lrow_s2;
		fx_s3   <= fx_s2;
		fy_s3   <= fy_s2;
		nb_s3   <= nb;
	end

	for (genvar n = 0; n < 4; n++) begin : g_dec
		always_comb begin
			case (pixel_mode_q)
				MODE_DIRECT: px[n] = nb_s3[n];
				MODE_GREY:   px[n] = {24'd0, nb_s3[n][7:0]};
				default:     px[n] = pal_rd[n];
			endcase
		end
	end

	assign pa_l = px[0];
	assign pb_l = lrow_s3 ? px[1] : px[2];
	assign pa_r = px[1];
	assign pb_r = px[3];
	assign fb   = lrow_s3 ? fx_s3 : fy_s3;
	assign fa   = ONE - {1'b0, fb};

	// stage 4: per channel left/right sums
	logic          smp_s4, lcol_s4, lrow_s4;
	logic [F-1:0]  fx_s4;
	word_t         tl_s4;
	logic [LW-1:0] l_s4 [3];
	logic [LW-1:0] r_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s4 <= 1'b0;
		end else begin
			smp_s4 <= smp_s3;
		end
	end

	always_ff @(posedge clk) begin
		lcol_s4 <= lcol_s3;
		lrow_s4 <= lrow_s3;
		fx_s4   <= fx_s3;
		tl_s4   <= px[0];
	end

	for (genvar c = 0; c < 3; c++) begin : g_yb
		always_ff @(posedge clk) begin
			l_s4[c] <= LW'(fa * pa_l[(2-c)*8 +: 8]) + LW'(fb * pb_l[(2-c)*8 +: 8]);
			r_s4[c] <= LW'(fa * pa_r[(2-c)*8 +: 8]) + LW'(fb * pb_r[(2-c)*8 +: 8]);
		end
	end

	// stage 5: x blend and edge cases, output register
	logic        vld_s5;
	word_t       color_s5;
	logic [F:0]  fxa;
	logic [23:0] mix, half;

	assign fxa = ONE - {1'b0, fx_s4};

	for (genvar c = 0; c < 3; c++) begin : g_xb
		logic [MW-1:0] m;

		assign m = MW'(fxa * l_s4[c]) + MW'(fx_s4 * r_s4[c]);
		assign mix[(2-c)*8 +: 8]  = m[2*F +: 8];
		assign half[(2-c)*8 +: 8] = l_s4[c][F +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= smp_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (lrow_s4 && (lcol_s4 || fx_s4 == '0))
			color_s5 <= tl_s4;
		else if (lrow_s4 || lcol_s4)
			color_s5 <= {ALPHA_OPAQUE, half};
		else
			color_s5 <= {ALPHA_OPAQUE, mix};
	end

	assign color_out   = color_s5;
	assign color_valid = vld_s5;

endmodule

>>> rtl/tbs_checker.sv
// tbs_checker: port level checks on command to result timing of the sampler.
// Depends on tbs_pkg (command codes); bound onto tile_bilinear_sampler_unit below.
module tbs_checker
	import tbs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  command,
	input logic        color_valid,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	logic smp_take, other_take;

	assign smp_take   = start && !busy && (command == CMD_SAMPLE);
	assign other_take = start && !busy && (command != CMD_SAMPLE);

	a_sample_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		smp_take |-> ##5 color_valid)
		else $error("sample gave no result word");

	a_no_word_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		other_take |-> ##5 !color_valid)
		else $error("result word after a non-sample command");

	a_word_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> $past(smp_take, 5))
		else $error("result word without a sample");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write held off");

endmodule

bind tile_bilinear_sampler_unit tbs_checker u_tbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.color_valid (color_valid),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);
